// ----- design/fpq_pkg.sv -----
`timescale 1ns / 1ps

package fpq_pkg;

    // Q format of the frequency fields
    localparam int FRAC_BITS = 12;
    // log2 fraction bits and mantissa fraction bits
    localparam int LOG_FRAC  = 24;
    localparam int MANT_BITS = 30;
    // integer quotient bits of the offset step number
    localparam int DIV_INT_BITS = 22;
    localparam int DIV_BITS     = DIV_INT_BITS + MANT_BITS;
    // offset that keeps the step number nonnegative
    localparam int N_OFFSET = 8192;

    localparam logic [31:0] BASE_RESET  = 32'(440 << FRAC_BITS);
    localparam logic [7:0]  STEPS_RESET = 8'd12;
    localparam logic [30:0] OUT_MAX     = '1;

    // register select, from paddr[2]
    typedef enum logic {
        REG_BASE  = 1'b0,
        REG_STEPS = 1'b1
    } t_reg_sel;

    // truncating integer square root, elaboration only
    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.30 by repeated square roots of 2.0
    function automatic logic [30:0] f_root(input int k);
        logic [63:0] root;
        root = 64'd2 << MANT_BITS;
        for (int j = 1; j <= MANT_BITS; j++) begin
            if (j <= k) begin
                root = f_isqrt(root << MANT_BITS);
            end
        end
        return root[30:0];
    endfunction

endpackage

// ----- design/frequency_pitch_quantizer.sv -----
`timescale 1ns / 1ps

// Equal-tempered pitch quantizer.
// Input channel: i_valid / o_stall carry one signed Q19.12 frequency per
// transaction. Output channel: o_valid / i_stall carry the quantized
// unsigned Q19.12 frequency, saturated at its maximum, zero when the base,
// the step count or the input is zero.
// Configuration: APB-style port, base frequency at 0x0, steps per octave
// at 0x4 (low 8 bits). Write only while no transaction is in flight.
// Pipeline: 2 input and normalize stages, 24 log2 squaring stages, 2
// stages for the scaled difference and rounding, 52 long-division stages
// (one quotient bit each), 30 exp2 factor stages and 2 output stages.
// Throughput is one transaction per cycle while the output is not stalled;
// each log2 stage holds two multipliers, each exp2 stage one multiplier
// and each division stage one narrow compare and subtract.
// Reset (synchronous, active low) empties the pipeline and loads base
// 440 Hz and 12 steps. When the receiver stalls with a result waiting, the
// whole pipeline holds and o_stall rises; nothing is dropped or repeated.
module frequency_pitch_quantizer import fpq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_frequency_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_frequency_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int LG_ST = LOG_FRAC;
    localparam int EX_ST = MANT_BITS;

    // msb index and Q1.30 mantissa of a value in [1, 2^31]
    typedef struct packed {
        logic [4:0]  e;
        logic [30:0] m;
    } t_norm;

    function automatic t_norm f_norm(input logic [31:0] x);
        t_norm o;
        o.e = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                o.e = 5'(i);
            end
        end
        if (o.e == 5'd31) begin
            o.m = x[31:1];
        end else begin
            o.m = 31'(x << (5'd30 - o.e));
        end
        return o;
    endfunction

    // configuration registers
    logic signed [31:0] r_base;
    logic [7:0]         r_steps;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_steps <= STEPS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_sel'(paddr[2]))
                REG_BASE:  r_base  <= pwdata;
                REG_STEPS: r_steps <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_sel'(paddr[2]))
            REG_BASE:  prdata = r_base;
            REG_STEPS: prdata = {24'b0, r_steps};
            default:   prdata = '0;
        endcase
    end

    // pipeline advance: hold only when a result waits and is stalled
    logic r_out_vld;
    logic w_adv;
    assign w_adv   = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_out_vld;

    logic [31:0] w_bm;
    assign w_bm = r_base[31] ? 32'(-r_base) : 32'(r_base);

    // stage A: magnitude and disable flag
    logic        r_a_vld;
    logic [31:0] r_a_fm;
    logic        r_a_dis;
    logic [31:0] n_a_fm;
    assign n_a_fm = i_frequency_in[31] ? 32'(-i_frequency_in) : 32'(i_frequency_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_fm  <= n_a_fm;
            r_a_dis <= (n_a_fm == '0) || (w_bm == '0) || (r_steps == '0);
        end
    end

    // log2 lanes; index 0 is the normalize stage output
    logic        r_lg_vld  [0:LG_ST];
    logic        r_lg_dis  [0:LG_ST];
    logic [30:0] r_lg_fm_m [0:LG_ST];
    logic [28:0] r_lg_fm_r [0:LG_ST];
    logic [30:0] r_lg_bm_m [0:LG_ST];
    logic [28:0] r_lg_bm_r [0:LG_ST];

    t_norm n_fm_norm;
    t_norm n_bm_norm;
    assign n_fm_norm = f_norm(r_a_fm);
    assign n_bm_norm = f_norm(w_bm);

    // stage B: normalize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_lg_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lg_dis[0]  <= r_a_dis;
            r_lg_fm_m[0] <= n_fm_norm.m;
            r_lg_fm_r[0] <= {n_fm_norm.e, 24'b0};
            r_lg_bm_m[0] <= n_bm_norm.m;
            r_lg_bm_r[0] <= {n_bm_norm.e, 24'b0};
        end
    end

    // one squaring per lane per stage, one fraction bit each
    for (genvar g = 0; g < LG_ST; g++) begin : g_log
        logic [61:0] n_fm_sq;
        logic [61:0] n_bm_sq;
        logic [31:0] n_fm_t;
        logic [31:0] n_bm_t;
        assign n_fm_sq = 62'(r_lg_fm_m[g]) * 62'(r_lg_fm_m[g]);
        assign n_bm_sq = 62'(r_lg_bm_m[g]) * 62'(r_lg_bm_m[g]);
        assign n_fm_t  = n_fm_sq[61:30];
        assign n_bm_t  = n_bm_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lg_vld[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_lg_vld[g+1] <= r_lg_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_lg_dis[g+1]  <= r_lg_dis[g];
                r_lg_fm_m[g+1] <= n_fm_t[31] ? n_fm_t[31:1] : n_fm_t[30:0];
                r_lg_bm_m[g+1] <= n_bm_t[31] ? n_bm_t[31:1] : n_bm_t[30:0];
                r_lg_fm_r[g+1] <= r_lg_fm_r[g] | (29'(n_fm_t[31]) << (LG_ST - 1 - g));
                r_lg_bm_r[g+1] <= r_lg_bm_r[g] | (29'(n_bm_t[31]) << (LG_ST - 1 - g));
            end
        end
    end

    // stage C: scaled log difference
    logic               r_c_vld;
    logic               r_c_dis;
    logic signed [38:0] r_c_p;
    logic signed [29:0] n_c_d;
    assign n_c_d = $signed({1'b0, r_lg_fm_r[LG_ST]}) - $signed({1'b0, r_lg_bm_r[LG_ST]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= r_lg_vld[LG_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_dis <= r_lg_dis[LG_ST];
            r_c_p   <= 39'(n_c_d) * $signed({31'b0, r_steps});
        end
    end

    // stage D: round to step number, add offset times steps
    logic                    r_d_vld;
    logic                    r_d_dis;
    logic [DIV_BITS-1:0]     r_d_num;
    logic signed [38:0]      n_d_pr;
    logic signed [14:0]      n_d_n;
    logic [DIV_INT_BITS-1:0] n_d_off;
    assign n_d_pr  = r_c_p + 39'sd8388608;
    assign n_d_n   = n_d_pr[38:24];
    assign n_d_off = DIV_INT_BITS'(r_steps) << $clog2(N_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_dis <= r_c_dis;
            r_d_num <= {DIV_INT_BITS'(n_d_n) + n_d_off, {MANT_BITS{1'b0}}};
        end
    end

    // long division by steps, one quotient bit per stage
    logic                r_dv_vld [0:DIV_BITS];
    logic                r_dv_dis [0:DIV_BITS];
    logic [DIV_BITS-1:0] r_dv_dq  [0:DIV_BITS];
    logic [7:0]          r_dv_rem [0:DIV_BITS];

    assign r_dv_vld[0] = r_d_vld;
    assign r_dv_dis[0] = r_d_dis;
    assign r_dv_dq[0]  = r_d_num;
    assign r_dv_rem[0] = '0;

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
        logic [8:0] n_trial;
        logic       n_ge;
        assign n_trial = {r_dv_rem[g], r_dv_dq[g][DIV_BITS-1]};
        assign n_ge    = n_trial >= {1'b0, r_steps};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[g+1] <= r_dv_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_dis[g+1] <= r_dv_dis[g];
                r_dv_dq[g+1]  <= {r_dv_dq[g][DIV_BITS-2:0], n_ge};
                r_dv_rem[g+1] <= n_ge ? 8'(n_trial - {1'b0, r_steps}) : n_trial[7:0];
            end
        end
    end

    // exp2 of the fraction, one root factor per stage
    logic                    r_ex_vld  [0:EX_ST];
    logic                    r_ex_dis  [0:EX_ST];
    logic [DIV_BITS-1:0]     r_ex_dq   [0:EX_ST];
    logic [30:0]             r_ex_m    [0:EX_ST];

    assign r_ex_vld[0] = r_dv_vld[DIV_BITS];
    assign r_ex_dis[0] = r_dv_dis[DIV_BITS];
    assign r_ex_dq[0]  = r_dv_dq[DIV_BITS];
    assign r_ex_m[0]   = 31'(1) << MANT_BITS;

    for (genvar g = 0; g < EX_ST; g++) begin : g_exp
        localparam logic [30:0] ROOT = f_root(g + 1);
        logic [61:0] n_prod;
        assign n_prod = 62'(r_ex_m[g]) * 62'(ROOT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ex_vld[g+1] <= 1'b0;
            end else if (w_adv) begin
                r_ex_vld[g+1] <= r_ex_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ex_dis[g+1] <= r_ex_dis[g];
                r_ex_dq[g+1]  <= r_ex_dq[g];
                r_ex_m[g+1]   <= r_ex_dq[g][MANT_BITS-1-g] ? n_prod[60:30] : r_ex_m[g];
            end
        end
    end

    // stage E: scale by base, form the binary exponent
    logic               r_e_vld;
    logic               r_e_dis;
    logic [62:0]        r_e_prod;
    logic signed [22:0] r_e_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_ex_vld[EX_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_dis  <= r_ex_dis[EX_ST];
            r_e_prod <= 63'(w_bm) * 63'(r_ex_m[EX_ST]);
            r_e_s    <= $signed({1'b0, r_ex_dq[EX_ST][DIV_BITS-1:MANT_BITS]})
                        - 23'(N_OFFSET + MANT_BITS);
        end
    end

    // stage F: shift, saturate, output register
    logic [30:0]        r_out_data;
    logic [30:0]        n_out;
    logic signed [22:0] n_ns;
    logic [62:0]        n_sh;

    assign n_ns = -r_e_s;

    always_comb begin
        n_sh  = '0;
        n_out = '0;
        if (r_e_dis) begin
            n_out = '0;
        end else if (r_e_s >= 0) begin
            if (r_e_s >= 23'sd32 || r_e_prod > 63'(OUT_MAX >> r_e_s[4:0])) begin
                n_out = OUT_MAX;
            end else begin
                n_sh  = r_e_prod << r_e_s[4:0];
                n_out = n_sh[30:0];
            end
        end else if (n_ns >= 23'sd64) begin
            n_out = '0;
        end else begin
            n_sh  = r_e_prod >> n_ns[5:0];
            n_out = (n_sh > 63'(OUT_MAX)) ? OUT_MAX : n_sh[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out;
        end
    end

    assign o_frequency_out = r_out_data;

endmodule

// ----- design/fpq_checker.sv -----
`timescale 1ns / 1ps

module fpq_checker import fpq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [30:0] o_frequency_out,
    input logic        psel,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] prdata
);

    // a waiting, stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frequency_out))
        else $error("stalled output changed");

    // input stalls exactly when a result waits and is stalled
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output backpressure");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // steps register reads back 8 bits only
    a_steps_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && (paddr[2] == REG_STEPS) |-> prdata[31:8] == '0)
        else $error("steps register read has upper bits set");

endmodule

bind frequency_pitch_quantizer fpq_checker u_fpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frequency_out (o_frequency_out),
    .psel            (psel),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .prdata          (prdata)
);
